@@ rtl/voice_segment_histogram_match_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the voice segment histogram matcher
// ---------------------------------------------------------------------------
`ifndef VOICE_SEGMENT_HISTOGRAM_MATCH_ASSERT_SVH
`define VOICE_SEGMENT_HISTOGRAM_MATCH_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off while in reset
`define VSHM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define VSHM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/vshm_pkg.sv @@
// ---------------------------------------------------------------------------
// vshm_pkg
// Shared constants, register codes and divider bundles of the matcher.
// ---------------------------------------------------------------------------
`default_nettype none

package vshm_pkg;

  // Geometry
  localparam int unsigned BINS        = 100;
  localparam int unsigned BLOCK_LEN   = 128;
  localparam int unsigned MAX_SAMPLES = 65536;

  localparam int unsigned BinW   = $clog2(BINS);
  localparam int unsigned FillW  = $clog2(BLOCK_LEN);
  localparam int unsigned CntW   = $clog2(BLOCK_LEN + 1);
  localparam int unsigned PosW   = $clog2(MAX_SAMPLES) + 1;

  // Field widths
  localparam int unsigned SmpW   = 16;
  localparam int unsigned EnW    = 23;
  localparam int unsigned LenW   = 16;
  localparam int unsigned NumSegW = 3;
  localparam int unsigned ScoreW = 15;
  localparam int unsigned SegW   = 14;
  localparam int unsigned TotW   = 16;
  localparam int unsigned FracW  = 8;

  // Memory words
  localparam int unsigned AW_A   = CntW + SegW;   // {block count, segment bin}
  localparam int unsigned AW_B   = 2 * TotW;      // {total bin, template bin}

  // Divider
  localparam int unsigned NumW   = TotW + FracW;
  localparam int unsigned DenW   = TotW + 1;

  // Configuration port
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 23;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_QUIET_LEVEL  = 4'd0,
    CFG_START_LEVEL  = 4'd1,
    CFG_STOP_LEVEL   = 4'd2,
    CFG_MIN_SEGMENT  = 4'd3,
    CFG_MAX_SEGMENT  = 4'd4,
    CFG_MAX_SEGMENTS = 4'd5,
    CFG_SCORE_LIMIT  = 4'd6,
    CFG_MIN_GOOD     = 4'd7
  } cfg_idx_e;

  // Register reset values
  localparam logic [EnW-1:0]     RstQuiet   = 23'd163840;
  localparam logic [EnW-1:0]     RstStart   = 23'd262144;
  localparam logic [EnW-1:0]     RstStop    = 23'd196608;
  localparam logic [LenW-1:0]    RstMinSeg  = 16'd5000;
  localparam logic [LenW-1:0]    RstMaxSeg  = 16'd9000;
  localparam logic [NumSegW-1:0] RstMaxSegs = 3'd5;
  localparam logic [ScoreW-1:0]  RstLimit   = 15'd10240;
  localparam logic [NumSegW-1:0] RstMinGood = 3'd2;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [NumW-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ rtl/vshm_ifs.sv @@
// ---------------------------------------------------------------------------
// vshm channel interfaces
// Sample, result and configuration channels with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface vshm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic signed [vshm_pkg::SmpW-1:0] sample;
  logic                          last;

  modport source (output valid, func, sample, last, input ready);
  modport sink   (input valid, func, sample, last, output ready);
endinterface

interface vshm_out_if;
  logic                              valid;
  logic                              ready;
  logic [vshm_pkg::NumSegW-1:0]      good_segments;
  logic [vshm_pkg::ScoreW-1:0]       score;
  logic                              accepted;
  logic                              was_enroll;

  modport source (output valid, good_segments, score, accepted, was_enroll,
                  input ready);
  modport sink   (input valid, good_segments, score, accepted, was_enroll,
                  output ready);
endinterface

interface vshm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [vshm_pkg::CfgIdxW-1:0]   index;
  logic [vshm_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/vshm_ram.sv @@
// ---------------------------------------------------------------------------
// vshm_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module vshm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(Depth)-1:0] waddr_i,
  input  wire  [Width-1:0]         wdata_i,
  input  wire  [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/vshm_div.sv @@
// ---------------------------------------------------------------------------
// vshm_div
// Restoring divider, one quotient bit per cycle, unsigned.
// ---------------------------------------------------------------------------
`default_nettype none

module vshm_div (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  vshm_pkg::div_req_t  req_i,
  output vshm_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned NumW = vshm_pkg::NumW;
  localparam int unsigned DenW = vshm_pkg::DenW;
  localparam int unsigned StW  = $clog2(NumW);

  logic [NumW-1:0] num_q;   // numerator shifts out, quotient shifts in
  logic [DenW-1:0] den_q;
  logic [DenW-1:0] rem_q;
  logic [StW-1:0]  step_q;
  logic            busy_q;
  logic            done_q;

  logic [DenW:0]   rem_sh;
  logic            fits;

  // Trial subtract
  assign rem_sh = {rem_q, num_q[NumW-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        num_q  <= req_i.num;
        den_q  <= req_i.den;
        rem_q  <= '0;
        step_q <= StW'(NumW - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q  <= fits ? DenW'(rem_sh - {1'b0, den_q}) : rem_sh[DenW-1:0];
        num_q  <= {num_q[NumW-2:0], fits};
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = num_q;

endmodule

`default_nettype wire

@@ rtl/voice_segment_histogram_match.sv @@
// ---------------------------------------------------------------------------
// voice_segment_histogram_match
// Block-energy segment detector with cumulative amplitude histograms,
// template enrollment and histogram distance scoring.
// ---------------------------------------------------------------------------
// Each sample is a RAM read, then a write-back of its bin count; no new sample
// is taken until that and any sweep or pass below are done. A sample that completes
// a 128-sample block adds a sweep through the histogram RAMs. The last sample adds
// a final pass over every bin, which uses the shared bit-serial divider.
// After reset a clearing pass zeroes the RAMs; no sample is taken
// during it, configuration writes are.
`default_nettype none

module voice_segment_histogram_match (
  input  wire  clk_i,
  input  wire  rst_ni,
  vshm_in_if.sink    in_i,
  vshm_out_if.source out_o,
  vshm_cfg_if.sink   cfg_i
);

  localparam int unsigned BINS  = vshm_pkg::BINS;
  localparam int unsigned BinW  = vshm_pkg::BinW;
  localparam int unsigned FillW = vshm_pkg::FillW;
  localparam int unsigned CntW  = vshm_pkg::CntW;
  localparam int unsigned PosW  = vshm_pkg::PosW;
  localparam int unsigned EnW   = vshm_pkg::EnW;
  localparam int unsigned LenW  = vshm_pkg::LenW;
  localparam int unsigned NsW   = vshm_pkg::NumSegW;
  localparam int unsigned ScW   = vshm_pkg::ScoreW;
  localparam int unsigned SegW  = vshm_pkg::SegW;
  localparam int unsigned TotW  = vshm_pkg::TotW;
  localparam int unsigned SmpW  = vshm_pkg::SmpW;
  localparam int unsigned NumW  = vshm_pkg::NumW;
  localparam int unsigned DenW  = vshm_pkg::DenW;
  localparam int unsigned FracW = vshm_pkg::FracW;
  localparam int unsigned MulW  = SmpW - 1 + BinW;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_INC, S_BLK, S_FRD, S_FLAT, S_FDIV, S_FSC, S_FSDIV, S_FWR, S_OUT
  } state_e;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic [EnW-1:0]  quiet_lvl_q, start_lvl_q, stop_lvl_q;
  logic [LenW-1:0] min_seg_q, max_seg_q;
  logic [NsW-1:0]  max_segs_q, min_good_q;
  logic [ScW-1:0]  limit_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_lvl_q <= vshm_pkg::RstQuiet;
      start_lvl_q <= vshm_pkg::RstStart;
      stop_lvl_q  <= vshm_pkg::RstStop;
      min_seg_q   <= vshm_pkg::RstMinSeg;
      max_seg_q   <= vshm_pkg::RstMaxSeg;
      max_segs_q  <= vshm_pkg::RstMaxSegs;
      limit_q     <= vshm_pkg::RstLimit;
      min_good_q  <= vshm_pkg::RstMinGood;
    end else if (cfg_i.valid) begin
      case (vshm_pkg::cfg_idx_e'(cfg_i.index))
        vshm_pkg::CFG_QUIET_LEVEL:  quiet_lvl_q <= cfg_i.data[EnW-1:0];
        vshm_pkg::CFG_START_LEVEL:  start_lvl_q <= cfg_i.data[EnW-1:0];
        vshm_pkg::CFG_STOP_LEVEL:   stop_lvl_q  <= cfg_i.data[EnW-1:0];
        vshm_pkg::CFG_MIN_SEGMENT:  min_seg_q   <= cfg_i.data[LenW-1:0];
        vshm_pkg::CFG_MAX_SEGMENT:  max_seg_q   <= cfg_i.data[LenW-1:0];
        vshm_pkg::CFG_MAX_SEGMENTS: max_segs_q  <= cfg_i.data[NsW-1:0];
        vshm_pkg::CFG_SCORE_LIMIT:  limit_q     <= cfg_i.data[ScW-1:0];
        vshm_pkg::CFG_MIN_GOOD:     min_good_q  <= cfg_i.data[NsW-1:0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // State
  // -------------------------------------------------------------------------
  state_e          state_q;
  logic [EnW-1:0]  energy_q;
  logic [FillW-1:0] fill_q;
  logic [PosW-1:0] pos_q, seg_start_q;
  logic            quiet_q, inseg_q, halted_q;
  logic [NsW-1:0]  good_q, closed_q;

  // pending sample
  logic [BinW-1:0] idx_q;
  logic            do_hist_q, blk_end_q, last_q, func_q;

  // sweeps
  logic [BinW-1:0] rd_addr_q, wr_addr_q;
  logic            issue_q, wr_vld_q;
  logic [CntW-1:0] run_q;
  logic            clr_seg_q, add_blk_q, add_tot_q;

  // final pass
  logic [TotW-1:0] tmpl_q, nb_q;
  logic [ScW-1:0]  score_q;

  // result register
  logic            out_vld_q;
  logic [NsW-1:0]  out_good_q;
  logic [ScW-1:0]  out_score_q;
  logic            out_acc_q, out_enr_q;

  // -------------------------------------------------------------------------
  // Sample front end
  // -------------------------------------------------------------------------
  logic            in_acc, proc;
  logic [SmpW:0]   mag;
  logic [EnW:0]    e_sum;
  logic [MulW-1:0] prod;
  logic [BinW-1:0] idx_in;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign proc       = !halted_q && (pos_q < PosW'(vshm_pkg::MAX_SAMPLES));
  assign mag        = in_i.sample[SmpW-1] ? (SmpW+1)'(-{in_i.sample[SmpW-1], in_i.sample})
                                          : {1'b0, in_i.sample};
  assign e_sum      = {1'b0, energy_q} + (EnW+1)'(mag);
  assign prod       = MulW'(in_i.sample[SmpW-2:0]) * MulW'(BINS);
  assign idx_in     = prod[MulW-1:SmpW-1];

  // -------------------------------------------------------------------------
  // Histogram RAMs
  // -------------------------------------------------------------------------
  logic                      we_a, we_b;
  logic [BinW-1:0]           waddr, raddr;
  logic [vshm_pkg::AW_A-1:0] wdata_a, rdata_a;
  logic [vshm_pkg::AW_B-1:0] wdata_b, rdata_b;

  logic [CntW-1:0] rd_cnt;
  logic [SegW-1:0] rd_seg, seg0, seg_new;
  logic [TotW-1:0] rd_tot, rd_tmpl, tot_new;
  logic [SegW:0]   seg_sum;
  logic [TotW:0]   tot_sum;

  assign rd_cnt  = rdata_a[vshm_pkg::AW_A-1:SegW];
  assign rd_seg  = rdata_a[SegW-1:0];
  assign rd_tot  = rdata_b[vshm_pkg::AW_B-1:TotW];
  assign rd_tmpl = rdata_b[TotW-1:0];

  // Block sweep arithmetic: saturating merges
  assign seg0    = clr_seg_q ? '0 : rd_seg;
  assign seg_sum = {1'b0, seg0} + (SegW+1)'(run_q);
  assign seg_new = !add_blk_q ? seg0 : (seg_sum[SegW] ? '1 : seg_sum[SegW-1:0]);
  assign tot_sum = {1'b0, rd_tot} + (TotW+1)'(seg0);
  assign tot_new = !add_tot_q ? rd_tot : (tot_sum[TotW] ? '1 : tot_sum[TotW-1:0]);

  assign raddr = (state_q == S_IDLE) ? idx_in : rd_addr_q;

  always_comb begin
    we_a    = 1'b0;
    we_b    = 1'b0;
    waddr   = rd_addr_q;
    wdata_a = '0;
    wdata_b = '0;
    case (state_q)
      S_CLR: begin
        we_a = 1'b1;
        we_b = 1'b1;
      end
      S_INC: begin
        we_a    = do_hist_q;
        waddr   = idx_q;
        wdata_a = {CntW'(rd_cnt + 1'b1), rd_seg};
      end
      S_BLK: begin
        we_a    = wr_vld_q;
        we_b    = wr_vld_q;
        waddr   = wr_addr_q;
        wdata_a = {CntW'(0), seg_new};
        wdata_b = {tot_new, rd_tmpl};
      end
      S_FWR: begin
        we_a    = 1'b1;
        we_b    = 1'b1;
        wdata_b = {TotW'(0), func_q ? tmpl_q : nb_q};
      end
      default: ;
    endcase
  end

  vshm_ram #(.Width(vshm_pkg::AW_A), .Depth(BINS)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata_a),
    .raddr_i (raddr),
    .rdata_o (rdata_a)
  );

  vshm_ram #(.Width(vshm_pkg::AW_B), .Depth(BINS)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata_b),
    .raddr_i (raddr),
    .rdata_o (rdata_b)
  );

  // -------------------------------------------------------------------------
  // Divider: total / good count, then 256*|a-b| / (a+b)
  // -------------------------------------------------------------------------
  vshm_pkg::div_req_t div_req;
  vshm_pkg::div_rsp_t div_rsp;
  logic [TotW-1:0]    diff;
  logic [DenW-1:0]    bsum;
  logic [ScW:0]       sc_sum;

  assign diff   = (tmpl_q > nb_q) ? TotW'(tmpl_q - nb_q) : TotW'(nb_q - tmpl_q);
  assign bsum   = {1'b0, tmpl_q} + {1'b0, nb_q};
  assign sc_sum = {1'b0, score_q} + (ScW+1)'(div_rsp.quo[ScW-1:0]);

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = {diff, FracW'(0)};
    div_req.den   = bsum;
    if (state_q == S_FLAT) begin
      div_req.start = (good_q != '0);
      div_req.num   = NumW'(rd_tot);
      div_req.den   = DenW'(good_q);
    end else if (state_q == S_FSC) begin
      div_req.start = func_q && (bsum != '0);
    end
  end

  vshm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // -------------------------------------------------------------------------
  // Block decision, from the completed block's energy
  // -------------------------------------------------------------------------
  logic            q1, opn, ins1, cls, len_ok, len_over;
  logic [PosW-1:0] blk_start, len;

  assign blk_start = pos_q - PosW'(vshm_pkg::BLOCK_LEN);
  assign q1        = quiet_q || (energy_q < quiet_lvl_q);
  assign opn       = q1 && !inseg_q && (energy_q > start_lvl_q);
  assign ins1      = inseg_q || opn;
  assign cls       = ins1 && (energy_q < stop_lvl_q);
  assign len       = blk_start - (opn ? blk_start : seg_start_q);
  assign len_ok    = (len > PosW'(min_seg_q)) && (len < PosW'(max_seg_q));
  assign len_over  = len > PosW'(max_seg_q);

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      energy_q    <= '0;
      fill_q      <= '0;
      pos_q       <= '0;
      seg_start_q <= '0;
      quiet_q     <= 1'b0;
      inseg_q     <= 1'b0;
      halted_q    <= 1'b0;
      good_q      <= '0;
      closed_q    <= '0;
      idx_q       <= '0;
      do_hist_q   <= 1'b0;
      blk_end_q   <= 1'b0;
      last_q      <= 1'b0;
      func_q      <= 1'b0;
      rd_addr_q   <= '0;
      wr_addr_q   <= '0;
      issue_q     <= 1'b0;
      wr_vld_q    <= 1'b0;
      run_q       <= '0;
      clr_seg_q   <= 1'b0;
      add_blk_q   <= 1'b0;
      add_tot_q   <= 1'b0;
      tmpl_q      <= '0;
      nb_q        <= '0;
      score_q     <= '0;
      out_vld_q   <= 1'b0;
      out_good_q  <= '0;
      out_score_q <= '0;
      out_acc_q   <= 1'b0;
      out_enr_q   <= 1'b0;
    end else begin
      if (out_vld_q && out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        // zero both RAMs after reset
        S_CLR: begin
          rd_addr_q <= rd_addr_q + 1'b1;
          if (rd_addr_q == BinW'(BINS - 1)) begin
            rd_addr_q <= '0;
            state_q   <= S_IDLE;
          end
        end

        // take a sample beat, read its bin count
        S_IDLE: begin
          if (in_acc) begin
            idx_q     <= idx_in;
            do_hist_q <= proc && !in_i.sample[SmpW-1] && (idx_in != '0);
            blk_end_q <= proc && (fill_q == FillW'(vshm_pkg::BLOCK_LEN - 1));
            last_q    <= in_i.last;
            func_q    <= in_i.func;
            if (proc) begin
              energy_q <= e_sum[EnW] ? '1 : e_sum[EnW-1:0];
              fill_q   <= (fill_q == FillW'(vshm_pkg::BLOCK_LEN - 1)) ? '0
                                                                       : fill_q + 1'b1;
              pos_q    <= pos_q + 1'b1;
            end
            state_q <= S_INC;
          end
        end

        // count written back; judge a full block
        S_INC: begin
          if (blk_end_q) begin
            quiet_q   <= q1;
            inseg_q   <= ins1 && !cls;
            if (opn) begin
              seg_start_q <= blk_start;
            end
            if (cls) begin
              if (closed_q != '1) closed_q <= closed_q + 1'b1;
              if (len_ok) begin
                if (good_q != '1) good_q <= good_q + 1'b1;
              end else begin
                if (len_over) good_q <= '0;
                halted_q <= 1'b1;
              end
            end
            clr_seg_q <= opn;
            add_blk_q <= ins1 && !cls;
            add_tot_q <= cls && len_ok;
            energy_q  <= '0;
            rd_addr_q <= BinW'(BINS - 1);
            issue_q   <= 1'b1;
            wr_vld_q  <= 1'b0;
            run_q     <= '0;
            state_q   <= S_BLK;
          end else if (last_q) begin
            if (closed_q > max_segs_q) good_q <= '0;
            rd_addr_q <= '0;
            score_q   <= '0;
            state_q   <= S_FRD;
          end else begin
            state_q <= S_IDLE;
          end
        end

        // descending sweep: suffix sums of counts feed the segment histogram
        S_BLK: begin
          if (issue_q) begin
            rd_addr_q <= rd_addr_q - 1'b1;
            issue_q   <= (rd_addr_q != '0);
          end
          wr_vld_q  <= issue_q;
          wr_addr_q <= rd_addr_q;
          if (wr_vld_q) begin
            run_q <= run_q + rd_cnt;
            if (wr_addr_q == '0) begin
              wr_vld_q <= 1'b0;
              if (last_q) begin
                if (closed_q > max_segs_q) good_q <= '0;
                rd_addr_q <= '0;
                score_q   <= '0;
                state_q   <= S_FRD;
              end else begin
                state_q <= S_IDLE;
              end
            end
          end
        end

        // final pass, one bin at a time
        S_FRD: state_q <= S_FLAT;

        S_FLAT: begin
          tmpl_q <= rd_tmpl;
          nb_q   <= rd_tot;
          state_q <= (good_q != '0) ? S_FDIV : S_FSC;
        end

        S_FDIV: begin
          if (div_rsp.done) begin
            nb_q    <= div_rsp.quo[TotW-1:0];
            state_q <= S_FSC;
          end
        end

        S_FSC: begin
          state_q <= (func_q && (bsum != '0)) ? S_FSDIV : S_FWR;
        end

        S_FSDIV: begin
          if (div_rsp.done) begin
            score_q <= sc_sum[ScW] ? '1 : sc_sum[ScW-1:0];
            state_q <= S_FWR;
          end
        end

        S_FWR: begin
          if (rd_addr_q == BinW'(BINS - 1)) begin
            state_q <= S_OUT;
          end else begin
            rd_addr_q <= rd_addr_q + 1'b1;
            state_q   <= S_FRD;
          end
        end

        // load the result beat and start a fresh recording
        S_OUT: begin
          if (!out_vld_q || out_o.ready) begin
            out_vld_q   <= 1'b1;
            out_good_q  <= good_q;
            out_score_q <= func_q ? score_q : '0;
            out_acc_q   <= func_q && (score_q <= limit_q) && (good_q >= min_good_q);
            out_enr_q   <= !func_q;
            energy_q    <= '0;
            fill_q      <= '0;
            pos_q       <= '0;
            seg_start_q <= '0;
            quiet_q     <= 1'b0;
            inseg_q     <= 1'b0;
            halted_q    <= 1'b0;
            good_q      <= '0;
            closed_q    <= '0;
            rd_addr_q   <= '0;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.good_segments = out_good_q;
  assign out_o.score         = out_score_q;
  assign out_o.accepted      = out_acc_q;
  assign out_o.was_enroll    = out_enr_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
`include "voice_segment_histogram_match_assert.svh"

  `VSHM_ASSERT_IMP(a_good_le_closed, 1'b1, good_q <= closed_q, "good count above closed count")
  `VSHM_ASSERT_IMP(a_halt_closed, halted_q, !inseg_q, "segment open while halted")
  `VSHM_ASSERT_IMP(a_seg_armed, inseg_q, quiet_q, "segment open without a quiet block")
  `VSHM_ASSERT_IMP(a_div_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
  `VSHM_ASSERT_NXT(a_out_load, (state_q == S_OUT) && !out_vld_q, out_vld_q,
                   "result beat not loaded")

endmodule

`default_nettype wire
